>>> hw/rtl/trd_pkg.sv
// Shared types, constants and helpers for the tilemap run-length decoder.
package trd_pkg;

	localparam int unsigned CodeW    = 8;
	localparam int unsigned CountW   = 6;
	localparam int unsigned TileW    = 8;
	localparam int unsigned PosW     = 6;
	localparam int unsigned CprW     = 7;
	localparam int unsigned LimitW   = 13;
	localparam int unsigned CfgAddrW = 1;
	localparam int unsigned CfgDataW = 13;
	localparam int unsigned OutDataW = 48;
	localparam int unsigned FifoDepth = 2;

	// Configuration register indexes.
	localparam logic [CfgAddrW-1:0] REG_COLUMNS_PER_ROW = 1'b0;
	localparam logic [CfgAddrW-1:0] REG_BYTE_LIMIT      = 1'b1;

	localparam logic [CprW-1:0]   COLUMNS_RESET = 7'd32;
	localparam logic [LimitW-1:0] LIMIT_RESET   = 13'd1024;
	localparam logic [LimitW-1:0] BYTES_MAX     = 13'h1FFF;
	localparam logic [CodeW-1:0]  END_CODE      = 8'hFF;

	// Mode field of a control byte.
	localparam logic [1:0] MODE_PAIR = 2'b11;
	localparam logic [1:0] MODE_REP  = 2'b10;
	localparam logic [1:0] MODE_INC  = 2'b01;
	localparam logic [1:0] MODE_LIT  = 2'b00;

	typedef enum logic [2:0] {
		CMD_PAIR,
		CMD_REP,
		CMD_INC,
		CMD_LIT,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CountW-1:0] count;
		logic [TileW-1:0]  tile_a;
		logic [TileW-1:0]  tile_b;
		logic              clr;
	} cmd_t;

	typedef struct packed {
		logic [PosW-1:0] row;
		logic [PosW-1:0] column;
	} pos_t;

	// Step one placement forward, wrapping at the row width or at 64.
	function automatic pos_t advance(pos_t p, logic [CprW-1:0] cpr);
		logic [CprW-1:0] nxt;
		pos_t            r;
		nxt = {1'b0, p.column} + 7'd1;
		if (nxt >= cpr || nxt[CprW-1]) begin
			r.column = '0;
			r.row    = p.row + 6'd1;
		end else begin
			r.column = nxt[PosW-1:0];
			r.row    = p.row;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/tilemap_rle_decoder.sv
// Top level of the tilemap run-length decoder: configuration registers and the two halves.
//
//  Channel  Signals                          Carries
//  -------  -------------------------------  ---------------------------------------------
//  s_*      s_tvalid s_tready s_tdata s_tuser one compressed byte; s_tuser = restart
//  m_*      m_tvalid m_tready m_tdata m_tlast one result of up to two placements;
//           m_tuser                           m_tlast = last of its byte, m_tuser = done
//  cfg_*    cfg_we cfg_addr cfg_wdata         register writes, no read-back
//
// The parser accepts a byte whenever the two-entry command queue has room.
// A run expands in the generator at one result per cycle while the output register
// can take it, once the command is loaded from the queue; the parser stalls only
// when both queue entries wait behind it.
// The output register holds a result while m_tready is low and the generator stops.
// Reset is asynchronous and needs no clearing pass; the first byte is taken right after.
module tilemap_rle_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] code_byte
	input  logic                          s_tuser,   // [0] restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] tiles_in_result, [9:2] first_tile, [15:10] first_column,
	// [21:16] first_row, [29:22] second_tile, [35:30] second_column,
	// [41:36] second_row, [47:42] zero fill
	output logic [trd_pkg::OutDataW-1:0]  m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser,   // [0] done_res
	input  logic                          cfg_we,
	input  logic [trd_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [trd_pkg::CfgDataW-1:0]  cfg_wdata
);
	import trd_pkg::*;

	logic [CprW-1:0]   columns_per_row_q;
	logic [LimitW-1:0] byte_limit_q;

	logic fifo_full;
	logic fifo_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	// Configuration is to be written by the user only while the decoder is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_per_row_q <= COLUMNS_RESET;
			byte_limit_q      <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_COLUMNS_PER_ROW: columns_per_row_q <= cfg_wdata[CprW-1:0];
				REG_BYTE_LIMIT:      byte_limit_q      <= cfg_wdata[LimitW-1:0];
				default: begin
				end
			endcase
		end
	end

	// The parser owns the byte count, the end flag and the operand sequencing.
	trd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.byte_limit (byte_limit_q),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	trd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.head     (head),
		.empty    (fifo_empty)
	);

	// The generator owns the column and row; a restart reaches it as a flag on
	// the next command, so the position clears in stream order.
	trd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.columns_per_row (columns_per_row_q),
		.fifo_empty      (fifo_empty),
		.head            (head),
		.pop             (pop),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser)
	);

endmodule

>>> hw/rtl/trd_cmd_fifo.sv
// Two-entry command queue between the byte parser and the result generator.
module trd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output trd_pkg::cmd_t head,
	output logic          empty
);
	import trd_pkg::*;

	cmd_t       mem_q [FifoDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'(FifoDepth));
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/trd_front.sv
// Byte parser: walks the control and operand bytes and queues run commands.
module trd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        s_tuser,
	input  logic [trd_pkg::LimitW-1:0]  byte_limit,
	input  logic                        fifo_full,
	output logic                        push,
	output trd_pkg::cmd_t               push_cmd
);
	import trd_pkg::*;

	typedef enum logic [2:0] {
		PH_CTRL,
		PH_PAIR_A,
		PH_PAIR_B,
		PH_REP,
		PH_INC,
		PH_LIT
	} phase_t;

	phase_t            phase_q, phase_e, phase_n;
	logic [CountW-1:0] run_q, run_e, run_n;
	logic [TileW-1:0]  held_q, held_n;
	logic [LimitW-1:0] bytes_q, bytes_e, bytes_n;
	logic              ended_q, ended_e, ended_n;
	logic              clr_pend_q;
	logic              accept;
	logic              push_req;
	logic [CountW-1:0] lit_left;

	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;
	assign lit_left = run_e - 6'd1;

	// A command enters the queue only on the beat that carries its last byte.
	assign push     = accept && push_req;

	// A restart clears the parser before the byte is looked at.
	always_comb begin
		if (s_tuser) begin
			phase_e = PH_CTRL;
			run_e   = '0;
			bytes_e = '0;
			ended_e = 1'b0;
		end else begin
			phase_e = phase_q;
			run_e   = run_q;
			bytes_e = bytes_q;
			ended_e = ended_q;
		end
	end

	always_comb begin
		phase_n         = phase_e;
		run_n           = run_e;
		held_n          = held_q;
		ended_n         = ended_e;
		bytes_n         = bytes_e;
		push_req        = 1'b0;
		push_cmd.kind   = CMD_END;
		push_cmd.count  = 6'd1;
		push_cmd.tile_a = s_tdata;
		push_cmd.tile_b = s_tdata;
		push_cmd.clr    = clr_pend_q || s_tuser;
		if (!ended_e) begin
			bytes_n = (bytes_e == BYTES_MAX) ? bytes_e : bytes_e + 13'd1;
			case (phase_e)
				PH_PAIR_A: begin
					held_n  = s_tdata;
					phase_n = PH_PAIR_B;
				end
				PH_PAIR_B: begin
					push_req        = (run_e != '0);
					push_cmd.kind   = CMD_PAIR;
					push_cmd.count  = run_e;
					push_cmd.tile_a = held_q;
					phase_n         = PH_CTRL;
				end
				PH_REP: begin
					push_req       = (run_e != '0);
					push_cmd.kind  = CMD_REP;
					push_cmd.count = run_e;
					phase_n        = PH_CTRL;
				end
				PH_INC: begin
					push_req       = (run_e != '0);
					push_cmd.kind  = CMD_INC;
					push_cmd.count = run_e;
					phase_n        = PH_CTRL;
				end
				PH_LIT: begin
					push_req      = 1'b1;
					push_cmd.kind = CMD_LIT;
					run_n         = lit_left;
					if (lit_left == '0) begin
						phase_n = PH_CTRL;
					end
				end
				default: begin
					if (s_tdata == END_CODE || bytes_e >= byte_limit) begin
						push_req = 1'b1;
						ended_n  = 1'b1;
						phase_n  = PH_CTRL;
					end else begin
						run_n = s_tdata[CountW-1:0];
						case (s_tdata[7:6])
							MODE_PAIR: phase_n = PH_PAIR_A;
							MODE_REP:  phase_n = PH_REP;
							MODE_INC:  phase_n = PH_INC;
							default:   phase_n = (s_tdata[CountW-1:0] != '0) ? PH_LIT : PH_CTRL;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CTRL;
			run_q      <= '0;
			held_q     <= '0;
			bytes_q    <= '0;
			ended_q    <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			run_q      <= run_n;
			held_q     <= held_n;
			bytes_q    <= bytes_n;
			ended_q    <= ended_n;
			clr_pend_q <= push ? 1'b0 : (clr_pend_q || s_tuser);
		end
	end

endmodule

>>> hw/rtl/trd_back.sv
// Result generator: expands queued commands into placements and tracks the position.
module trd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [trd_pkg::CprW-1:0]      columns_per_row,
	input  logic                          fifo_empty,
	input  trd_pkg::cmd_t                 head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [trd_pkg::OutDataW-1:0]  m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);
	import trd_pkg::*;

	cmd_t              cur_q;
	logic [CountW-1:0] rem_q;
	logic              busy_q;
	pos_t              pos_q;
	logic              m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	logic              fire;
	pos_t              p1, p2, pos1, pos2, pos_nxt;
	logic [1:0]        tiles;
	logic [TileW-1:0]  t1, t2;
	logic              done;

	assign pop  = !busy_q && !fifo_empty;
	assign fire = busy_q && (!m_tvalid_q || m_tready);
	assign p1   = advance(pos_q, columns_per_row);
	assign p2   = advance(p1, columns_per_row);

	always_comb begin
		tiles   = 2'd1;
		t1      = cur_q.tile_a;
		t2      = '0;
		pos1    = pos_q;
		pos2    = '0;
		pos_nxt = p1;
		done    = 1'b0;
		case (cur_q.kind)
			CMD_PAIR: begin
				tiles   = 2'd2;
				t2      = cur_q.tile_b;
				pos2    = p1;
				pos_nxt = p2;
			end
			CMD_END: begin
				tiles   = 2'd0;
				t1      = '0;
				pos1    = '0;
				pos_nxt = pos_q;
				done    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rem_q      <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= head.count;
				if (head.clr) begin
					pos_q <= '0;
				end
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
				pos_q      <= pos_nxt;
				rem_q      <= rem_q - 6'd1;
				if (rem_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (fire && cur_q.kind == CMD_INC) begin
			cur_q.tile_a <= cur_q.tile_a + 8'd1;
		end
		if (fire) begin
			m_tdata_q <= {6'b0, pos2.row, pos2.column, t2, pos1.row, pos1.column, t1, tiles};
			m_tlast_q <= (rem_q == 6'd1);
			m_tuser_q <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> hw/rtl/trd_checker.sv
// Port-level checks on the decoder's result stream, bound to the top level.
module trd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [trd_pkg::OutDataW-1:0]  m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);
	import trd_pkg::*;

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// The end marker carries no placement and closes its beat group.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == 2'd0 && m_tlast && m_tdata[41:2] == '0)
		else $error("end marker malformed");

	// Only the end marker has no placement.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tuser)
		else $error("empty result without done");

	// Single placements leave the second slot zero, and no result holds three.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd2 |-> m_tdata[41:22] == '0 && m_tdata[1:0] != 2'd3)
		else $error("second placement set in a single result");

endmodule

bind tilemap_rle_decoder trd_checker u_trd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

>>> tb/sv/tilemap_rle_checker.sv
// Checker for the tilemap run-length decoder: predicts placements and compares them.
module tilemap_rle_checker
	import trd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	input  logic                m_tlast,
	input  logic                m_tuser,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output int                  fail_count,
	output int                  outstanding
);

	typedef enum logic [2:0] {
		WAIT_CTRL,
		TAKE_A,
		TAKE_B,
		TAKE_REP,
		TAKE_INC,
		TAKE_LIT
	} decode_phase_t;

	// Same bit order as {m_tuser, m_tlast, m_tdata[41:0]}.
	typedef struct packed {
		logic            done;
		logic            last;
		logic [PosW-1:0]  row_b;
		logic [PosW-1:0]  col_b;
		logic [TileW-1:0] tile_b;
		logic [PosW-1:0]  row_a;
		logic [PosW-1:0]  col_a;
		logic [TileW-1:0] tile_a;
		logic [1:0]       tiles;
	} placement_t;

	logic [CprW-1:0]   row_width;
	logic [LimitW-1:0] limit;
	decode_phase_t     phase;
	logic [1:0]        mode;
	logic [CountW-1:0] run_len;
	logic [TileW-1:0]  held;
	logic [PosW-1:0]   col;
	logic [PosW-1:0]   row;
	logic [LimitW-1:0] consumed;
	logic              ended;
	placement_t        expected_placements[$];
	int                mismatches = 0;

	task automatic clear_decoder();
		phase    = WAIT_CTRL;
		mode     = MODE_LIT;
		run_len  = '0;
		held     = '0;
		col      = '0;
		row      = '0;
		consumed = '0;
		ended    = 1'b0;
	endtask

	// The column wraps at the row width or at 64, whichever comes first.
	task automatic step_position();
		logic [CprW-1:0] nxt;
		nxt = {1'b0, col} + 7'd1;
		if (nxt >= row_width || nxt >= 7'd64) begin
			col = '0;
			row = row + 6'd1;
		end else begin
			col = nxt[PosW-1:0];
		end
	endtask

	task automatic place(input logic [1:0] tiles, input logic [TileW-1:0] tile_a,
			input logic pair, input logic [TileW-1:0] tile_b, input logic done);
		placement_t p;
		p       = '0;
		p.tiles = tiles;
		p.done  = done;
		if (tiles != 2'd0) begin
			p.tile_a = tile_a;
			p.col_a  = col;
			p.row_a  = row;
			step_position();
			if (pair) begin
				p.tile_b = tile_b;
				p.col_b  = col;
				p.row_b  = row;
				step_position();
			end
		end
		expected_placements.push_back(p);
	endtask

	task automatic predict_placements(input logic [7:0] code, input logic restart);
		logic [LimitW-1:0] prior;
		logic [TileW-1:0]  t;
		placement_t        tail;
		int                first_new;
		int                i;
		first_new = expected_placements.size();
		if (restart)
			clear_decoder();
		if (ended)
			return;
		prior = consumed;
		if (consumed != BYTES_MAX)
			consumed = consumed + 1'b1;
		case (phase)
			TAKE_A: begin
				held  = code;
				phase = TAKE_B;
			end
			TAKE_B: begin
				for (i = 0; i < run_len; i++)
					place(2'd2, held, 1'b1, code, 1'b0);
				phase = WAIT_CTRL;
			end
			TAKE_REP: begin
				held = code;
				for (i = 0; i < run_len; i++)
					place(2'd1, code, 1'b0, 8'd0, 1'b0);
				phase = WAIT_CTRL;
			end
			TAKE_INC: begin
				t = code;
				for (i = 0; i < run_len; i++) begin
					place(2'd1, t, 1'b0, 8'd0, 1'b0);
					t = t + 8'd1;
				end
				held  = t;
				phase = WAIT_CTRL;
			end
			TAKE_LIT: begin
				place(2'd1, code, 1'b0, 8'd0, 1'b0);
				run_len = run_len - 6'd1;
				if (run_len == '0)
					phase = WAIT_CTRL;
			end
			default: begin
				if (code == END_CODE || prior >= limit) begin
					ended = 1'b1;
					phase = WAIT_CTRL;
					place(2'd0, 8'd0, 1'b0, 8'd0, 1'b1);
				end else begin
					mode    = code[7:6];
					run_len = code[5:0];
					case (mode)
						MODE_PAIR: phase = TAKE_A;
						MODE_REP:  phase = TAKE_REP;
						MODE_INC:  phase = TAKE_INC;
						default:   phase = (run_len != '0) ? TAKE_LIT : WAIT_CTRL;
					endcase
				end
			end
		endcase
		if (expected_placements.size() > first_new) begin
			tail      = expected_placements.pop_back();
			tail.last = 1'b1;
			expected_placements.push_back(tail);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		placement_t got;
		if (!arst_n) begin
			clear_decoder();
			row_width = COLUMNS_RESET;
			limit     = LIMIT_RESET;
			expected_placements.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// Results are checked before the byte of this edge is predicted.
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tlast, m_tdata[41:0]};
				if (expected_placements.size() == 0) begin
					$display("%0t: result expected none, got %h", $time, got);
					mismatches++;
				end else begin
					want = expected_placements.pop_front();
					compare_field("tiles_in_result", want.tiles, got.tiles);
					compare_field("first_tile", want.tile_a, got.tile_a);
					compare_field("first_column", want.col_a, got.col_a);
					compare_field("first_row", want.row_a, got.row_a);
					compare_field("second_tile", want.tile_b, got.tile_b);
					compare_field("second_column", want.col_b, got.col_b);
					compare_field("second_row", want.row_b, got.row_b);
					compare_field("last", want.last, got.last);
					compare_field("done_res", want.done, got.done);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_COLUMNS_PER_ROW: row_width = cfg_wdata[CprW-1:0];
					REG_BYTE_LIMIT:      limit = cfg_wdata[LimitW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_placements(s_tdata, s_tuser);
			outstanding <= expected_placements.size();
			fail_count  <= mismatches;
		end
	end

endmodule

>>> tb/sv/tilemap_rle_decoder_test.sv
// Top of the tilemap run-length decoder testbench: clock, reset, stimulus and verdict.
module tilemap_rle_decoder_test;
	import trd_pkg::*;

	// The watchdog is far above the slowest legal run, with every byte
	// expanding into a long run while the receiver stalls.
	localparam int unsigned CYCLE_LIMIT  = 10_000_000;
	// Bytes that cause no result may still sit in the parser or the command
	// queue when the last result has left, so idle points wait this long.
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES  = 400;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic [7:0]          s_tdata   = '0;
	logic                s_tuser   = 1'b0;
	logic                m_tready  = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr  = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	logic                s_tready;
	logic                m_tvalid;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tlast;
	logic                m_tuser;

	int fail_count;
	int outstanding;

	// When calm is set neither side idles. A raised hold_req makes the
	// receiver stall for a long stretch; the receiver lowers it when done.
	bit calm       = 1'b0;
	bit hold_req   = 1'b0;
	int beats_sent = 0;

	tilemap_rle_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	tilemap_rle_checker placement_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The watchdog counts cycles and ends a hung run.
	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Idle gaps are mostly short, now and then long, and absent when calm.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Tile operands lean toward the extremes so that both ends are hit often.
	function automatic logic [7:0] pick_tile();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// The receiver runs in its own process. A hold request keeps m_tready low
	// for a long stretch so that the result register and the command queue
	// fill and the block stalls its input.
	initial begin : receiver
		int stall;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Offers one beat and returns at the edge that accepts it. With no gap the
	// valid stays high and only the data changes.
	task automatic send_byte(input logic [7:0] code, input logic restart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tuser  <= restart;
		do
			@(posedge clk);
		while (!s_tready);
		beats_sent++;
	endtask

	// A control byte followed by the operand bytes that its mode takes.
	task automatic send_command(input logic [1:0] mode, input logic [5:0] count,
			input logic restart);
		int k;
		send_byte({mode, count}, restart);
		case (mode)
			MODE_PAIR: begin
				send_byte(pick_tile(), 1'b0);
				send_byte(pick_tile(), 1'b0);
			end
			MODE_REP, MODE_INC: send_byte(pick_tile(), 1'b0);
			default: begin
				for (k = 0; k < count; k++)
					send_byte(pick_tile(), 1'b0);
			end
		endcase
	endtask

	// Stops offering and waits until every predicted result has arrived, then
	// lets the block settle. A wait before that lets the checker count the
	// byte that was accepted last.
	task automatic drain();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed commands with random content. The rest is noise
	// bytes, which may carry a restart and break a command in half, and end
	// codes, after which the next command restarts the stream.
	task automatic random_segment(input int quota, input int restart_pct);
		int         start;
		int         r;
		int         n;
		logic [1:0] mode;
		logic [5:0] count;
		logic [7:0] noise;
		logic       force_restart;
		start         = beats_sent;
		force_restart = 1'b1;
		while (beats_sent - start < quota) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				noise = 8'($urandom_range(0, 255));
				send_byte(noise, 1'($urandom_range(0, 1)));
			end else if (r < 12) begin
				send_byte(END_CODE, 1'b0);
				force_restart = 1'b1;
			end else begin
				mode = 2'($urandom_range(0, 3));
				n    = $urandom_range(0, 99);
				if (n < 10)
					count = 6'd0;
				else if (n < 75)
					count = 6'($urandom_range(1, 8));
				else if (n < 95)
					count = 6'($urandom_range(9, 30));
				else
					count = 6'($urandom_range(31, 63));
				send_command(mode, count,
					force_restart || ($urandom_range(0, 99) < restart_pct));
				force_restart = 1'b0;
			end
		end
	endtask

	// One register setting followed by random traffic. Small byte limits end
	// the stream after a few bytes, so there most commands restart it.
	task automatic run_phase(input int width, input int limit, input int quota);
		drain();
		write_reg(REG_COLUMNS_PER_ROW, CfgDataW'(width));
		write_reg(REG_BYTE_LIMIT, CfgDataW'(limit));
		calm = ($urandom_range(0, 2) == 0);
		random_segment(quota, (limit < 64) ? 60 : 10);
		calm = 1'b0;
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset setting of 32 columns and a 1024 byte
		// limit. A pair run with tiles at both extremes, the longest run,
		// which wraps over two rows, an incrementing run across 0xFF and a literal run.
		send_byte({MODE_PAIR, 6'd3}, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte({MODE_REP, 6'd63}, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte({MODE_INC, 6'd5}, 1'b0);
		send_byte(8'hFD, 1'b0);
		send_byte({MODE_LIT, 6'd3}, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		// Zero counts still take their operands and place nothing.
		send_byte({MODE_PAIR, 6'd0}, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte({MODE_INC, 6'd0}, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte({MODE_LIT, 6'd0}, 1'b0);
		// The end code, a byte that is ignored after it, then a restart.
		send_byte(END_CODE, 1'b0);
		send_byte({MODE_REP, 6'd1}, 1'b0);
		send_byte({MODE_INC, 6'd2}, 1'b1);
		send_byte(8'h10, 1'b0);
		// A restart in the middle of a pair command drops the command.
		send_byte({MODE_PAIR, 6'd2}, 1'b0);
		send_byte({MODE_REP, 6'd1}, 1'b1);
		send_byte(8'h07, 1'b0);
		send_byte(END_CODE, 1'b0);

		// The receiver holds off while long runs keep coming, then the sender
		// pauses until every result has been taken.
		drain();
		hold_req = 1'b1;
		send_byte({MODE_REP, 6'd63}, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte({MODE_PAIR, 6'd63}, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte({MODE_INC, 6'd63}, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte({MODE_REP, 6'd40}, 1'b0);
		send_byte(8'h99, 1'b0);
		drain();

		// Register settings, the range extremes among them. A width of zero
		// puts every tile in column 0, widths past 64 wrap at 64, and a byte
		// limit of zero ends the stream at the first control byte.
		run_phase(1, 4096, 20);
		run_phase(64, 4096, 22);
		run_phase(0, 20, 18);
		run_phase(7, 1, 16);
		run_phase(100, 0, 10);
		run_phase(13, 40, 22);
		run_phase(32, 1024, 22);

		drain();
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
